@@ design/ckspl_pkg.sv @@
package ckspl_pkg;

   localparam logic [1:0] KIND_NAME    = 2'd0;
   localparam logic [1:0] KIND_VALUE   = 2'd1;
   localparam logic [1:0] KIND_PAIREND = 2'd2;
   localparam logic [1:0] KIND_DROP    = 2'd3;

   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   localparam logic [1:0] HEX_IDLE = 2'd0;
   localparam logic [1:0] HEX_ONE  = 2'd1;
   localparam logic [1:0] HEX_TWO  = 2'd2;

   localparam int MaxResults = 3;

   typedef enum logic [2:0] {
      PH_NAME  = 3'b001,
      PH_VALUE = 3'b010,
      PH_SKIP  = 3'b100
   } phase_type;

   // up to three results caused by one input transaction
   typedef struct packed {
      logic [1:0]                 cnt;
      logic [MaxResults-1:0][7:0] data;
      logic [MaxResults-1:0][1:0] kind;
   } bundle_type;

   function automatic logic [7:0] plain_char(input logic [7:0] c);
      return (c == CHAR_PLUS) ? CHAR_SPACE : c;
   endfunction

   // {valid, digit}
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // two-character base-16 parse with optional leading space or sign
   function automatic logic [7:0] parse_pair(input logic [7:0] h, input logic [7:0] c);
      logic [4:0] hv;
      logic [4:0] cv;
      logic [7:0] r;
      hv = hex_val(h);
      cv = hex_val(c);
      r  = 8'd0;
      if (is_space(h)) begin
         r = cv[4] ? {4'd0, cv[3:0]} : 8'd0;
      end else if (h == CHAR_PLUS || h == CHAR_MINUS) begin
         if (cv[4]) begin
            r = (h == CHAR_MINUS) ? 8'(8'd0 - {4'd0, cv[3:0]}) : {4'd0, cv[3:0]};
         end
      end else if (hv[4]) begin
         r = cv[4] ? {hv[3:0], cv[3:0]} : {4'd0, hv[3:0]};
      end
      return r;
   endfunction

endpackage

@@ design/ckspl_front.sv @@
module ckspl_front
   import ckspl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] in_byte,
   input  logic       end_of_header,
   input  logic       q_full,
   output logic       q_wr,
   output bundle_type q_wdata
);

   phase_type  phase_ff, phase_in;
   logic [1:0] hex_ff, hex_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   bundle_type res;

   assign accept = push && !q_full;

   always_comb begin
      res      = '0;
      phase_in = phase_ff;
      hex_in   = hex_ff;
      held_in  = held_ff;
      case (phase_ff)
         PH_SKIP: begin
            phase_in = PH_NAME;
            if (end_of_header) begin
               res.cnt     = 2'd1;
               res.kind[0] = KIND_DROP;
            end
         end
         PH_VALUE: begin
            case (hex_ff)
               HEX_ONE: begin
                  if (in_byte == CHAR_SEMI) begin
                     res.data[0] = CHAR_PERCENT;
                     res.kind[0] = KIND_VALUE;
                     res.kind[1] = KIND_PAIREND;
                     res.cnt     = 2'd2;
                     hex_in      = HEX_IDLE;
                     phase_in    = PH_SKIP;
                     if (end_of_header) begin
                        res.kind[2] = KIND_DROP;
                        res.cnt     = 2'd3;
                     end
                  end else if (end_of_header) begin
                     res.data[0] = CHAR_PERCENT;
                     res.kind[0] = KIND_VALUE;
                     res.data[1] = plain_char(in_byte);
                     res.kind[1] = KIND_VALUE;
                     res.kind[2] = KIND_PAIREND;
                     res.cnt     = 2'd3;
                  end else begin
                     held_in = in_byte;
                     hex_in  = HEX_TWO;
                  end
               end
               HEX_TWO: begin
                  if (in_byte == CHAR_SEMI) begin
                     res.data[0] = CHAR_PERCENT;
                     res.kind[0] = KIND_VALUE;
                     res.data[1] = plain_char(held_ff);
                     res.kind[1] = KIND_VALUE;
                     res.kind[2] = KIND_PAIREND;
                     res.cnt     = 2'd3;
                     hex_in      = HEX_IDLE;
                     phase_in    = PH_SKIP;
                  end else begin
                     res.data[0] = parse_pair(held_ff, in_byte);
                     res.kind[0] = KIND_VALUE;
                     res.cnt     = 2'd1;
                     hex_in      = HEX_IDLE;
                     if (end_of_header) begin
                        res.kind[1] = KIND_PAIREND;
                        res.cnt     = 2'd2;
                     end
                  end
               end
               default: begin
                  if (in_byte == CHAR_SEMI) begin
                     res.kind[0] = KIND_PAIREND;
                     res.cnt     = 2'd1;
                     phase_in    = PH_SKIP;
                     if (end_of_header) begin
                        res.kind[1] = KIND_DROP;
                        res.cnt     = 2'd2;
                     end
                  end else if (in_byte == CHAR_PERCENT) begin
                     if (end_of_header) begin
                        res.data[0] = CHAR_PERCENT;
                        res.kind[0] = KIND_VALUE;
                        res.kind[1] = KIND_PAIREND;
                        res.cnt     = 2'd2;
                     end else begin
                        hex_in = HEX_ONE;
                     end
                  end else begin
                     res.data[0] = plain_char(in_byte);
                     res.kind[0] = KIND_VALUE;
                     res.cnt     = 2'd1;
                     if (end_of_header) begin
                        res.kind[1] = KIND_PAIREND;
                        res.cnt     = 2'd2;
                     end
                  end
               end
            endcase
         end
         default: begin
            if (in_byte == CHAR_EQUAL) begin
               phase_in = PH_VALUE;
               hex_in   = HEX_IDLE;
               if (end_of_header) begin
                  res.kind[0] = KIND_PAIREND;
                  res.cnt     = 2'd1;
               end
            end else begin
               res.data[0] = in_byte;
               res.kind[0] = KIND_NAME;
               res.cnt     = 2'd1;
               if (end_of_header) begin
                  res.kind[1] = KIND_DROP;
                  res.cnt     = 2'd2;
               end
            end
         end
      endcase
      if (end_of_header) begin
         phase_in = PH_NAME;
         hex_in   = HEX_IDLE;
         held_in  = 8'd0;
      end
   end

   assign q_wr    = accept && (res.cnt != 2'd0);
   assign q_wdata = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NAME;
         hex_ff   <= HEX_IDLE;
         held_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hex_ff   <= hex_in;
         held_ff  <= held_in;
      end
   end

`ifndef SYNTHESIS
   a_escape_only_in_value: assert property (@(posedge clock) disable iff (reset)
      (hex_ff != HEX_IDLE) |-> (phase_ff == PH_VALUE))
      else $error("escape pending outside value");
   a_header_end_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_header) |=> (phase_ff == PH_NAME && hex_ff == HEX_IDLE))
      else $error("parse state not cleared at header end");
`endif

endmodule

@@ design/ckspl_queue.sv @@
module ckspl_queue
   import ckspl_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr,
   input  bundle_type wdata,
   output logic       full,
   input  logic       rd,
   output bundle_type rdata,
   output logic       empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type           slots_ff [DEPTH];
   logic [AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_ff + 1'b1);
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_ff + 1'b1);
      end
      if (wr && !rd) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (rd && !wr) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         slots_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count overflow");
   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      wr |-> !full)
      else $error("write into full queue");
   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      rd |-> !empty)
      else $error("read from empty queue");
`endif

endmodule

@@ design/ckspl_back.sv @@
module ckspl_back
   import ckspl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  bundle_type q_rdata,
   output logic       q_rd,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_last_of_run
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic [1:0] kind_ff;
   logic       last_ff;
   logic       load;
   logic       is_last;

   assign load    = !q_empty && (!valid_ff || rsp_pop);
   assign is_last = (idx_ff == 2'(q_rdata.cnt - 2'd1));
   assign q_rd    = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? 2'd0 : 2'(idx_ff + 2'd1);
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= q_rdata.data[idx_ff];
         kind_ff <= q_rdata.kind[idx_ff];
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_last_of_run = last_ff;

`ifndef SYNTHESIS
   a_index_in_bundle: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (idx_ff < q_rdata.cnt))
      else $error("result index beyond bundle");
`endif

endmodule

@@ design/cookie_header_splitter_decoder_top.sv @@
// path: a result is written into the bundle queue, then into the registered rsp port
// throughput: one input byte per cycle while the bundle queue has room
// each input yields zero to three results; the back end drains one result per cycle
// while the receiver pops, so an input with k results holds the output side for k pops
// reset: synchronous, active high; clears parse state, queue pointers and output valid
module cookie_header_splitter_decoder_top
   import ckspl_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   // input transaction side
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_header,
   // result transaction side
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_last_of_run
);

   // bundles of results travel from the parser to the drain through a short queue
   logic       q_wr;
   logic       q_rd;
   logic       q_full;
   logic       q_empty;
   bundle_type q_wdata;
   bundle_type q_rdata;

   // parser only stalls when the queue cannot take another bundle
   assign req_full = q_full;

   // front: cookie parse state, percent decode, builds one bundle per input
   ckspl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .in_byte       (req_in_byte),
      .end_of_header (req_end_of_header),
      .q_full        (q_full),
      .q_wr          (q_wr),
      .q_wdata       (q_wdata)
   );

   // decoupling queue, inputs with no results never enter it
   ckspl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .wdata (q_wdata),
      .full  (q_full),
      .rd    (q_rd),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   // back: walks each bundle and feeds the registered result port
   ckspl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_rdata         (q_rdata),
      .q_rd            (q_rd),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_kind        (rsp_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import ckspl_pkg::*;

   // run limit in clock cycles, far above the slowest legal run
   localparam int CYCLE_LIMIT = 400000;

   // one token out of the splitter: name byte, value byte or marker
   typedef struct {
      logic [7:0] data;
      logic [1:0] kind;
      logic       last;
   } cookie_token_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_end_of_header = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic       rsp_last_of_run;

   // tokens the splitter still owes us, oldest first
   cookie_token_type cookie_tokens[$];

   // parser state mirrored on the testbench side
   phase_type  parse_phase = PH_NAME;
   logic [1:0] esc_count = HEX_IDLE;
   logic [7:0] esc_char = 8'd0;

   int  fail_count = 0;
   int  bytes_sent = 0;
   int  cycle_count = 0;
   bit  send_gaps_on = 1'b1;
   bit  pop_gaps_on = 1'b1;
   // long receiver hold-off, picked up by the drain process
   int  pop_hold_cycles = 0;

   cookie_header_splitter_decoder_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_in_byte       (req_in_byte),
      .req_end_of_header (req_end_of_header),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_kind          (rsp_kind),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #6 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // --------------------------------------------------------------------
   // token prediction
   // --------------------------------------------------------------------

   function automatic void add_token(input logic [7:0] data, input logic [1:0] kind);
      cookie_token_type t;
      t.data = data;
      t.kind = kind;
      t.last = 1'b0;
      cookie_tokens.push_back(t);
   endfunction

   // '+' in a value reads as a space
   function automatic logic [7:0] plus_as_space(input logic [7:0] c);
      return (c == CHAR_PLUS) ? CHAR_SPACE : c;
   endfunction

   // hex digit weight, -1 when not a hex digit
   function automatic int nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   // advance the mirrored parser by one header byte and queue its tokens
   function automatic void split_cookie_byte(input logic [7:0] b, input logic eoh);
      int first_new;
      int hi;
      int lo;
      logic [7:0] decoded;
      first_new = cookie_tokens.size();
      case (parse_phase)
         PH_SKIP: begin
            // byte after ';' is thrown away
            parse_phase = PH_NAME;
            if (eoh) add_token(8'd0, KIND_DROP);
         end
         PH_VALUE: begin
            if (esc_count == HEX_ONE) begin
               if (b == CHAR_SEMI) begin
                  // escape cut off right after the percent sign
                  add_token(CHAR_PERCENT, KIND_VALUE);
                  add_token(8'd0, KIND_PAIREND);
                  esc_count = HEX_IDLE;
                  parse_phase = PH_SKIP;
                  if (eoh) add_token(8'd0, KIND_DROP);
               end else if (eoh) begin
                  add_token(CHAR_PERCENT, KIND_VALUE);
                  add_token(plus_as_space(b), KIND_VALUE);
                  add_token(8'd0, KIND_PAIREND);
               end else begin
                  esc_char = b;
                  esc_count = HEX_TWO;
               end
            end else if (esc_count == HEX_TWO) begin
               if (b == CHAR_SEMI) begin
                  // escape cut off with one character held
                  add_token(CHAR_PERCENT, KIND_VALUE);
                  add_token(plus_as_space(esc_char), KIND_VALUE);
                  add_token(8'd0, KIND_PAIREND);
                  esc_count = HEX_IDLE;
                  parse_phase = PH_SKIP;
               end else begin
                  // base-16 parse of the two characters
                  hi = nibble_of(esc_char);
                  lo = nibble_of(b);
                  decoded = 8'd0;
                  if (esc_char == CHAR_SPACE ||
                      (esc_char >= CHAR_TAB && esc_char <= CHAR_CR)) begin
                     if (lo >= 0) decoded = 8'(lo);
                  end else if (esc_char == CHAR_PLUS || esc_char == CHAR_MINUS) begin
                     if (lo >= 0) decoded = (esc_char == CHAR_MINUS) ? 8'(-lo) : 8'(lo);
                  end else if (hi >= 0) begin
                     decoded = (lo >= 0) ? 8'(hi * 16 + lo) : 8'(hi);
                  end
                  add_token(decoded, KIND_VALUE);
                  esc_count = HEX_IDLE;
                  if (eoh) add_token(8'd0, KIND_PAIREND);
               end
            end else begin
               if (b == CHAR_SEMI) begin
                  add_token(8'd0, KIND_PAIREND);
                  parse_phase = PH_SKIP;
                  if (eoh) add_token(8'd0, KIND_DROP);
               end else if (b == CHAR_PERCENT) begin
                  if (eoh) begin
                     add_token(CHAR_PERCENT, KIND_VALUE);
                     add_token(8'd0, KIND_PAIREND);
                  end else begin
                     esc_count = HEX_ONE;
                  end
               end else begin
                  add_token(plus_as_space(b), KIND_VALUE);
                  if (eoh) add_token(8'd0, KIND_PAIREND);
               end
            end
         end
         default: begin
            // in name: everything up to '=' passes raw
            if (b == CHAR_EQUAL) begin
               parse_phase = PH_VALUE;
               esc_count = HEX_IDLE;
               if (eoh) add_token(8'd0, KIND_PAIREND);
            end else begin
               add_token(b, KIND_NAME);
               if (eoh) add_token(8'd0, KIND_DROP);
            end
         end
      endcase
      // end of header puts the parser back to its reset state
      if (eoh) begin
         parse_phase = PH_NAME;
         esc_count = HEX_IDLE;
         esc_char = 8'd0;
      end
      if (cookie_tokens.size() > first_new) cookie_tokens[cookie_tokens.size() - 1].last = 1'b1;
   endfunction

   // --------------------------------------------------------------------
   // input side
   // --------------------------------------------------------------------

   // one input transaction, with a random gap in front of it
   task automatic send_byte(input logic [7:0] b, input logic eoh);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_in_byte <= b;
      req_end_of_header <= eoh;
      do @(posedge clock); while (req_full);
      split_cookie_byte(b, eoh);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input bit eoh_last);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], eoh_last && (i == s.len() - 1));
      end
   endtask

   // sender stops and waits for every owed token to come out
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (cookie_tokens.size() != 0) @(posedge clock);
   endtask

   // character inside an escape: mostly hex digits, sometimes space, sign or junk
   function automatic logic [7:0] escape_char();
      string hex_digits = "0123456789abcdefABCDEF";
      string odd_chars = " \t\r-+zG;";
      if ($urandom_range(0, 4) != 0) return hex_digits[$urandom_range(0, 21)];
      return odd_chars[$urandom_range(0, 7)];
   endfunction

   // header of name=value pairs with random content, sometimes cut short
   task automatic send_random_header();
      logic [7:0] hdr[$];
      int pairs;
      int n;
      int cut;
      pairs = $urandom_range(1, 3);
      for (int p = 0; p < pairs; p++) begin
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) hdr.push_back(8'($urandom_range(0, 255)));
            else hdr.push_back(8'($urandom_range(97, 122)));
         end
         hdr.push_back(CHAR_EQUAL);
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
               6: hdr.push_back(CHAR_PLUS);
               7, 8, 9: begin
                  hdr.push_back(CHAR_PERCENT);
                  hdr.push_back(escape_char());
                  hdr.push_back(escape_char());
               end
               default: hdr.push_back(8'($urandom_range(32, 126)));
            endcase
         end
         if (p != pairs - 1) begin
            hdr.push_back(CHAR_SEMI);
            hdr.push_back(CHAR_SPACE);
         end
      end
      // truncation lands the end of header on any parser state
      if ($urandom_range(0, 3) == 0) begin
         cut = $urandom_range(1, hdr.size());
         while (hdr.size() > cut) void'(hdr.pop_back());
      end
      for (int i = 0; i < hdr.size(); i++) send_byte(hdr[i], i == hdr.size() - 1);
   endtask

   // raw random bytes, end of header anywhere
   task automatic send_noise();
      int n;
      bit resync;
      n = $urandom_range(1, 8);
      resync = 1'($urandom_range(0, 1));
      for (int i = 0; i < n; i++) begin
         send_byte(8'($urandom_range(0, 255)),
                   ($urandom_range(0, 9) == 0) || (resync && i == n - 1));
      end
   endtask

   // --------------------------------------------------------------------
   // result side: random pop stalls, each accepted transaction is checked
   // --------------------------------------------------------------------

   initial begin : result_drain
      int gap;
      cookie_token_type want;
      wait (reset == 1'b0);
      forever begin
         if (pop_hold_cycles > 0) gap = pop_hold_cycles;
         else gap = pop_gaps_on ? $urandom_range(0, 19) : 0;
         pop_hold_cycles = 0;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (cookie_tokens.size() == 0) begin
            $error("unexpected result transaction: out_byte %02h kind %0d last_of_run %0b",
                   rsp_out_byte, rsp_kind, rsp_last_of_run);
            fail_count++;
         end else begin
            want = cookie_tokens.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %02h, got %02h", want.data, rsp_out_byte);
               fail_count++;
            end
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0b, got %0b", want.last, rsp_last_of_run);
               fail_count++;
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // tests
   // --------------------------------------------------------------------

   // field extremes, plus decoding, sign and space escapes, and several ways a header can end
   task automatic test_directed();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("=+%41%-5% z;x", 1'b0);
      // escape cut by ';', then end of header on the skipped byte
      send_text("=%;q", 1'b1);
      // escape cut by end of header on its first character
      send_text("=%+", 1'b1);
      // header ends on ';'
      send_text("=;", 1'b1);
      // header ends in name
      send_text("n", 1'b1);
      // header ends on a bare percent sign
      send_text("=%", 1'b1);
      wait_drained();
   endtask

   // receiver holds off so the block fills and raises full
   task automatic test_backpressure();
      send_gaps_on = 1'b0;
      pop_hold_cycles = 300;
      for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(97, 122)), i == 39);
      wait_drained();
      send_gaps_on = 1'b1;
   endtask

   task automatic test_random_headers();
      int start;
      start = bytes_sent;
      while (bytes_sent - start < 200) begin
         // stretches without gaps on either side
         send_gaps_on = ($urandom_range(0, 3) != 0);
         pop_gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) send_noise();
         else send_random_header();
      end
      send_gaps_on = 1'b1;
      pop_gaps_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_headers();
      wait_drained();
      // room for any stray transaction to show up
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

@@ cookie_header_splitter_decoder_top.f @@
design/ckspl_pkg.sv
design/ckspl_front.sv
design/ckspl_queue.sv
design/ckspl_back.sv
design/cookie_header_splitter_decoder_top.sv
sim/testbench.sv
